@@ design/dnl_pkg.sv @@
`timescale 1ns / 1ps

package dnl_pkg;

  // Status codes reported on the final byte of a name
  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_TOO_LONG    = 4'd1,
    ST_BARE_DOT    = 4'd2,
    ST_BUF_SMALL   = 4'd3,
    ST_WILDCARD    = 4'd4,
    ST_NON_ASCII   = 4'd5,
    ST_EMPTY_LABEL = 4'd6,
    ST_UNDER_START = 4'd7,
    ST_HYPHEN_START = 4'd8,
    ST_BAD_CHAR    = 4'd9,
    ST_LABEL_LONG  = 4'd10,
    ST_TRAIL_HYPHEN = 4'd11
  } status_t;

  // Result of one item, passed from the check unit to the output register
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
    status_t    status;
    logic [7:0] error_offset;
  } res_t;

  // Configuration port
  localparam int          PADDR_W          = 3;
  localparam int          PDATA_W          = 32;
  localparam logic        REG_OUT_CAPACITY = 1'b0;
  localparam logic [7:0]  CAP_RESET        = 8'd255;

  // Characters of interest
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CASE_BIT  = 8'h20;

endpackage

@@ design/dnl_cfg.sv @@
`timescale 1ns / 1ps

module dnl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dnl_pkg::PADDR_W-1:0] paddr,
  input  logic [dnl_pkg::PDATA_W-1:0] pwdata,
  output logic [dnl_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [7:0]                  out_capacity
);
  import dnl_pkg::*;

  logic hit;
  logic wr_en;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_OUT_CAPACITY);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (wr_en) begin
      out_capacity <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(PDATA_W-8){1'b0}}, out_capacity};
    end
  end

endmodule

@@ design/dnl_check.sv @@
`timescale 1ns / 1ps

module dnl_check #(
  parameter int MAX_NAME_LEN  = 253,
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [7:0]    in_byte,
  input  logic          is_last,
  input  logic [7:0]    out_capacity,
  output dnl_pkg::res_t res
);
  import dnl_pkg::*;

  localparam int CNT_W = $clog2(MAX_NAME_LEN + 2);
  localparam int LBL_W = $clog2(MAX_LABEL_LEN + 2);
  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [LBL_W-1:0] label_length, label_length_next;
  logic             after_dot, after_dot_next;
  logic [7:0]       previous_byte, previous_byte_next;
  logic             first_is_star, first_is_star_next;
  logic             dot_second, dot_second_next;
  status_t          first_error, first_error_next;
  logic [7:0]       first_error_offset, first_error_offset_next;

  logic             strip;
  logic             ldh;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] stripped;
  logic [LBL_W-1:0] label_inc;
  logic [CMP_W-1:0] need_len;
  logic [7:0]       tail_byte;

  always_comb begin
    strip = is_last && (in_byte == CH_DOT);
    total = (byte_count < CNT_W'(MAX_NAME_LEN + 1)) ? byte_count + 1'b1 : byte_count;
    stripped  = strip ? total - 1'b1 : total;
    need_len  = CMP_W'(stripped) + 1'b1;
    tail_byte = strip ? previous_byte : in_byte;
    label_inc = label_length + 1'b1;
    ldh = (in_byte inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], [CH_D0:CH_D9], CH_HYPHEN});

    byte_count_next         = total;
    label_length_next       = label_length;
    after_dot_next          = after_dot;
    previous_byte_next      = in_byte;
    first_error_next        = first_error;
    first_error_offset_next = first_error_offset;
    first_is_star_next = first_is_star || ((byte_count == '0) && (in_byte == CH_STAR));
    dot_second_next    = dot_second || ((byte_count == CNT_W'(1)) && (in_byte == CH_DOT));

    // Per-byte checks stop at the first error and past the length limit
    if (!strip && (first_error == ST_OK) && (byte_count < CNT_W'(MAX_NAME_LEN))) begin
      if (in_byte[7]) begin
        first_error_next = ST_NON_ASCII;
      end else if (in_byte == CH_DOT) begin
        if (after_dot) begin
          first_error_next = ST_EMPTY_LABEL;
        end else begin
          label_length_next = '0;
          after_dot_next    = 1'b1;
        end
      end else if (after_dot && (in_byte == CH_UNDER)) begin
        first_error_next = ST_UNDER_START;
      end else if (after_dot && (in_byte == CH_HYPHEN)) begin
        first_error_next = ST_HYPHEN_START;
      end else if (!ldh) begin
        first_error_next = ST_BAD_CHAR;
      end else begin
        label_length_next = label_inc;
        if (label_inc > LBL_W'(MAX_LABEL_LEN)) begin
          first_error_next = ST_LABEL_LONG;
        end else begin
          after_dot_next = 1'b0;
        end
      end
      if (first_error_next != ST_OK) begin
        first_error_offset_next = 8'(byte_count);
      end
    end

    res.out_char     = (in_byte inside {[CH_UA:CH_UZ]}) ? (in_byte | CASE_BIT) : in_byte;
    res.char_valid   = !strip;
    res.done_res     = is_last;
    res.status       = ST_OK;
    res.error_offset = '0;

    if (is_last) begin
      if (total > CNT_W'(MAX_NAME_LEN)) begin
        res.status = ST_TOO_LONG;
      end else if (stripped == '0) begin
        res.status = ST_BARE_DOT;
      end else if (need_len > CMP_W'(out_capacity)) begin
        res.status = ST_BUF_SMALL;
      end else if ((stripped >= CNT_W'(2)) && first_is_star_next && dot_second_next) begin
        res.status = ST_WILDCARD;
      end else if (first_error_next != ST_OK) begin
        res.status       = first_error_next;
        res.error_offset = first_error_offset_next;
      end else if (tail_byte == CH_HYPHEN) begin
        res.status = ST_TRAIL_HYPHEN;
      end

      // Start over for the next name
      byte_count_next         = '0;
      label_length_next       = '0;
      after_dot_next          = 1'b1;
      previous_byte_next      = '0;
      first_is_star_next      = 1'b0;
      dot_second_next         = 1'b0;
      first_error_next        = ST_OK;
      first_error_offset_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count         <= '0;
      label_length       <= '0;
      after_dot          <= 1'b1;
      previous_byte      <= '0;
      first_is_star      <= 1'b0;
      dot_second         <= 1'b0;
      first_error        <= ST_OK;
      first_error_offset <= '0;
    end else if (advance) begin
      byte_count         <= byte_count_next;
      label_length       <= label_length_next;
      after_dot          <= after_dot_next;
      previous_byte      <= previous_byte_next;
      first_is_star      <= first_is_star_next;
      dot_second         <= dot_second_next;
      first_error        <= first_error_next;
      first_error_offset <= first_error_offset_next;
    end
  end

endmodule

@@ design/domain_name_ldh_check.sv @@
`timescale 1ns / 1ps

// Streaming hostname check: takes a domain name one byte per item (is_last on
// the final byte) and returns one result item per byte, carrying the
// lower-cased byte, a flag that is low only for a stripped trailing dot, and
// on the final byte a status code with the offset of the first bad byte.
// One item is taken every cycle while in_stall is low; the per-name state (byte and
// label counts, first error) updates as each byte moves on, which is what sets
// that rate. A byte passes an input register and then a result register, where
// its result is held on the outputs while out_stall is high. out_capacity sits
// at byte address 0 of the register port and resets to 255; write it only while
// no name is in flight.
module domain_name_ldh_check #(
  parameter int MAX_NAME_LEN  = 253,
  parameter int MAX_LABEL_LEN = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_char,
  output logic                        char_valid,
  output logic                        done_res,
  output logic [3:0]                  status,
  output logic [7:0]                  error_offset,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dnl_pkg::PADDR_W-1:0] paddr,
  input  logic [dnl_pkg::PDATA_W-1:0] pwdata,
  output logic [dnl_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import dnl_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_move;
  logic       accept;
  logic [7:0] cap;
  res_t       res;
  res_t       out_res;

  dnl_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .out_capacity (cap)
  );

  dnl_check #(
    .MAX_NAME_LEN  (MAX_NAME_LEN),
    .MAX_LABEL_LEN (MAX_LABEL_LEN)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .advance      (s1_move),
    .in_byte      (s1_byte),
    .is_last      (s1_last),
    .out_capacity (cap),
    .res          (res)
  );

  // Input stage moves on whenever the result register is free or draining
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= in_byte;
      s1_last <= is_last;
    end
    if (s1_move) begin
      out_res <= res;
    end
  end

  assign out_char     = out_res.out_char;
  assign char_valid   = out_res.char_valid;
  assign done_res     = out_res.done_res;
  assign status       = out_res.status;
  assign error_offset = out_res.error_offset;

  a_mid_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> (status == ST_OK) && (error_offset == 8'd0))
    else $error("status or offset set on a non-final result");

  a_strip_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> done_res && (out_char == CH_DOT))
    else $error("dropped byte is not a final dot");

  a_offset_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_offset != 8'd0) |->
      (status == ST_NON_ASCII) || (status == ST_EMPTY_LABEL) ||
      (status == ST_UNDER_START) || (status == ST_HYPHEN_START) ||
      (status == ST_BAD_CHAR) || (status == ST_LABEL_LONG))
    else $error("offset reported with a whole-name status");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import dnl_pkg::*;

  localparam int NAME_MAX    = 253;
  localparam int LABEL_MAX   = 63;
  localparam int RAND_ITEMS  = 150;
  localparam int NUM_PHASES  = 6;
  localparam int HOLD_CYCLES = 40;
  localparam int SETTLE      = 6;
  localparam int LIMIT_NS    = 4_000_000;
  localparam int NUM_DIR     = 24;
  localparam int MAX_REPORTS = 50;
  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(REG_OUT_CAPACITY));

  typedef logic [7:0] name_bytes_t [$];
  typedef struct {
    int      fill;
    string   text;
    int      zero_at;
    bit      typed;
    status_t st;
    int      off;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_byte;
  logic is_last;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_char;
  logic char_valid;
  logic done_res;
  logic [3:0] status;
  logic [7:0] error_offset;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  domain_name_ldh_check dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: per-name scan plus the capacity register
  logic [7:0] cap_shadow;
  logic [8:0] nm_count;
  logic [6:0] lbl_len;
  logic       at_label_start;
  logic [7:0] prev_byte;
  logic       star_lead;
  logic       dot_at_one;
  status_t    first_err;
  logic [7:0] first_err_off;

  res_t expected_chars [$];
  res_t want;
  int err_count = 0;
  int byte_total = 0;
  int names_sent = 0;
  int cap_writes = 0;
  bit [15:0] status_seen = '0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  task automatic note_mismatch(input string what, input int got, input int exp_val);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  function automatic void clear_name_state();
    nm_count = '0;
    lbl_len = '0;
    at_label_start = 1'b1;
    prev_byte = '0;
    star_lead = 1'b0;
    dot_at_one = 1'b0;
    first_err = ST_OK;
    first_err_off = '0;
  endfunction

  function automatic void flag_first(input status_t code, input logic [8:0] off);
    first_err = code;
    first_err_off = off[7:0];
  endfunction

  function automatic void scan_byte(input logic [7:0] c, input logic [8:0] off);
    logic ldh;
    ldh = (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
          (c >= CH_D0 && c <= CH_D9) || c == CH_HYPHEN;
    // only the first offending byte counts; bytes past the length limit are skipped
    if (first_err == ST_OK && off < NAME_MAX) begin
      if (c[7]) begin
        flag_first(ST_NON_ASCII, off);
      end else if (c == CH_DOT) begin
        if (at_label_start) begin
          flag_first(ST_EMPTY_LABEL, off);
        end else begin
          lbl_len = '0;
          at_label_start = 1'b1;
        end
      end else if (at_label_start && c == CH_UNDER) begin
        flag_first(ST_UNDER_START, off);
      end else if (at_label_start && c == CH_HYPHEN) begin
        flag_first(ST_HYPHEN_START, off);
      end else if (!ldh) begin
        flag_first(ST_BAD_CHAR, off);
      end else begin
        lbl_len++;
        if (lbl_len > LABEL_MAX) flag_first(ST_LABEL_LONG, off);
        else at_label_start = 1'b0;
      end
    end
  endfunction

  function automatic res_t predict_char(input logic [7:0] c, input logic is_end);
    res_t r;
    logic [8:0] off;
    logic [8:0] total;
    logic [8:0] kept;
    logic strip;
    off = nm_count;
    strip = is_end && c == CH_DOT;
    if (nm_count < NAME_MAX + 1) nm_count++;
    total = nm_count;
    r.out_char = (c >= CH_UA && c <= CH_UZ) ? (c | CASE_BIT) : c;
    r.char_valid = !strip;
    r.done_res = is_end;
    r.status = ST_OK;
    r.error_offset = '0;
    if (off == 0 && c == CH_STAR) star_lead = 1'b1;
    if (off == 1 && c == CH_DOT) dot_at_one = 1'b1;
    if (!strip) scan_byte(c, off);
    if (is_end) begin
      kept = strip ? total - 9'd1 : total;
      if (total > NAME_MAX) begin
        r.status = ST_TOO_LONG;
      end else if (kept == 0) begin
        r.status = ST_BARE_DOT;
      end else if (int'(kept) + 1 > int'(cap_shadow)) begin
        r.status = ST_BUF_SMALL;
      end else if (kept >= 2 && star_lead && dot_at_one) begin
        r.status = ST_WILDCARD;
      end else if (first_err != ST_OK) begin
        r.status = first_err;
        r.error_offset = first_err_off;
      end else if ((strip ? prev_byte : c) == CH_HYPHEN) begin
        r.status = ST_TRAIL_HYPHEN;
      end
      clear_name_state();
    end else begin
      prev_byte = c;
    end
    return r;
  endfunction

  function automatic name_bytes_t filler(input int len);
    name_bytes_t q;
    for (int i = 0; i < len; i++)
      q.push_back((i % 64 == 63) ? CH_DOT : 8'(CH_LA + i % 26));
    return q;
  endfunction

  function automatic logic [7:0] ldh_char(input bit hyphen_ok);
    int r;
    r = $urandom_range(0, hyphen_ok ? 62 : 61);
    if (r < 26) return 8'(CH_LA + r);
    if (r < 52) return 8'(CH_UA + r - 26);
    if (r < 62) return 8'(CH_D0 + r - 52);
    return CH_HYPHEN;
  endfunction

  task automatic write_cap(input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_shadow = val;
    cap_writes++;
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== val) note_mismatch("out_capacity readback", prdata[7:0], val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_name(input name_bytes_t nm, input bit typed, input status_t st,
                           input int eoff);
    res_t r;
    for (int i = 0; i < nm.size(); i++) begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= nm[i];
      is_last  <= (i == nm.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      r = predict_char(nm[i], i == nm.size() - 1);
      if (typed && r.done_res) begin
        r.status = st;
        r.error_offset = 8'(eoff);
      end
      expected_chars.push_back(r);
      byte_total++;
    end
    names_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        note_mismatch("item with nothing expected, out_char", out_char, -1);
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.out_char) note_mismatch("out_char", out_char, want.out_char);
        if (char_valid !== want.char_valid)
          note_mismatch("char_valid", char_valid, want.char_valid);
        if (done_res !== want.done_res) note_mismatch("done_res", done_res, want.done_res);
        if (status !== want.status) note_mismatch("status", status, want.status);
        if (error_offset !== want.error_offset)
          note_mismatch("error_offset", error_offset, want.error_offset);
        if (want.done_res) status_seen[want.status] = 1'b1;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin
    dir_row_t dir_tab [NUM_DIR];
    name_bytes_t nm;
    logic [7:0] caps [NUM_PHASES];
    int goal;
    int kind;
    int n;
    int pos;

    rst     <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= '0;
    is_last <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cap_shadow = CAP_RESET;
    clear_name_state();

    dir_tab = '{
      '{0,   "example.com",   -1, 1'b1, ST_OK,           0},
      '{0,   "Example.COM.",  -1, 1'b1, ST_OK,           0},
      '{0,   ".",             -1, 1'b1, ST_BARE_DOT,     0},
      '{0,   "..",            -1, 1'b1, ST_EMPTY_LABEL,  0},
      '{0,   "*.example.com", -1, 1'b1, ST_WILDCARD,     0},
      '{0,   "*.",            -1, 1'b1, ST_BAD_CHAR,     0},
      '{0,   "*",             -1, 1'b1, ST_BAD_CHAR,     0},
      '{0,   "x.*",           -1, 1'b1, ST_BAD_CHAR,     2},
      '{0,   "a..b",          -1, 1'b1, ST_EMPTY_LABEL,  2},
      '{0,   ".a",            -1, 1'b1, ST_EMPTY_LABEL,  0},
      '{0,   "_srv.example",  -1, 1'b1, ST_UNDER_START,  0},
      '{0,   "a.-b",          -1, 1'b1, ST_HYPHEN_START, 2},
      '{0,   "a b",           -1, 1'b1, ST_BAD_CHAR,     1},
      '{0,   "a@[\140{/:",    -1, 1'b1, ST_BAD_CHAR,     1},
      '{0,   "ab\303",        -1, 1'b1, ST_NON_ASCII,    2},
      '{0,   "\377x",         -1, 1'b1, ST_NON_ASCII,    0},
      '{0,   "a?b",            1, 1'b1, ST_BAD_CHAR,     1},
      '{0,   "a-",            -1, 1'b1, ST_TRAIL_HYPHEN, 0},
      '{0,   "a-.",           -1, 1'b1, ST_TRAIL_HYPHEN, 0},
      '{0,   "AZaz09.x-y",    -1, 1'b1, ST_OK,           0},
      '{0,   "a.b..",         -1, 1'b0, ST_OK,           0},
      '{63,  "x",             -1, 1'b1, ST_LABEL_LONG,   63},
      '{253, "",              -1, 1'b1, ST_OK,           0},
      '{253, "..",            -1, 1'b1, ST_TOO_LONG,     0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < NUM_DIR; d++) begin
      nm = filler(dir_tab[d].fill);
      for (int k = 0; k < dir_tab[d].text.len(); k++)
        nm.push_back((k == dir_tab[d].zero_at) ? 8'h00 : dir_tab[d].text[k]);
      send_name(nm, dir_tab[d].typed, dir_tab[d].st, dir_tab[d].off);
    end

    caps[0] = 8'd1;
    caps[1] = 8'd0;
    caps[2] = 8'($urandom_range(2, 24));
    caps[3] = 8'd253;
    caps[4] = 8'($urandom_range(2, 64));
    caps[5] = 8'd255;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // drain every pending result before touching the register
      in_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
      write_cap(caps[ph]);
      idle_on = (ph != 3) && (ph != NUM_PHASES - 1);
      hold_req = (ph == 3);
      goal = byte_total + RAND_ITEMS / NUM_PHASES;
      while (byte_total < goal) begin
        kind = $urandom_range(0, 99);
        nm = {};
        if (kind < 4) begin
          nm = filler($urandom_range(248, 256));
          if ($urandom_range(0, 1)) nm.push_back(CH_DOT);
        end else if (kind < 10) begin
          n = $urandom_range(60, 66);
          repeat (n) nm.push_back(ldh_char(1'b0));
          nm.push_back(CH_DOT);
          nm.push_back(CH_LA);
        end else if (kind < 85) begin
          if ($urandom_range(0, 9) == 0) begin
            nm.push_back(CH_STAR);
            nm.push_back(CH_DOT);
          end
          repeat ($urandom_range(1, 4)) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) nm.push_back(ldh_char(k != 0 && k != n - 1));
            nm.push_back(CH_DOT);
          end
          if ($urandom_range(0, 3) != 0) void'(nm.pop_back());
          // break a well-formed name now and then
          if ($urandom_range(0, 9) < 3) begin
            pos = $urandom_range(0, nm.size() - 1);
            case ($urandom_range(0, 5))
              0: nm[pos] = CH_UNDER;
              1: nm[pos] = CH_HYPHEN;
              2: nm[pos] = CH_DOT;
              3: nm[pos] = CH_STAR;
              4: nm[pos] = 8'($urandom_range(0, 255));
              default: nm[nm.size() - ((nm[nm.size() - 1] == CH_DOT) ? 2 : 1)] = CH_HYPHEN;
            endcase
          end
        end else begin
          repeat ($urandom_range(1, 6)) nm.push_back(8'($urandom_range(0, 255)));
        end
        send_name(nm, 1'b0, ST_OK, 0);
      end
    end

    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);

    $display("run: %0d names, %0d bytes, %0d capacity settings from 0 to 255",
             names_sent, byte_total, cap_writes);
    $display("run: %0d of 12 status codes seen on final bytes", $countones(status_seen));
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
